FILE: rtl/mtbt_pkg.sv
package mtbt_pkg;

  // field widths of the request and result channels
  localparam int OP_W   = 3;
  localparam int BKT_W  = 10;
  localparam int CNT_W  = 16;
  localparam int STAT_W = 3;

  localparam int NUM_BUCKETS_DEF = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_FETCH   = 3'd2,
    OP_RETURN  = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_ARG   = 3'd1,
    STAT_NO_BUCKET = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_NO_TOKENS = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SCAN
  } state_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic             live;
    logic [CNT_W-1:0] tokens;
    logic [CNT_W-1:0] fill_rate;
    logic [CNT_W-1:0] burst_limit;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/mtbt_ram.sv
module mtbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/multi_token_bucket_table.sv
// Channel   Ports                                          Handshake
// request   in_op in_bucket in_rate in_capacity in_count   start & !busy
// result    out_status out_new_bucket out_granted          out_valid, one cycle
//
// Destroy, fetch and return: request edge issues the memory read, the next
// cycle modifies and writes back, and only then is a new request taken.
// Tick and create walk the table one entry a cycle: tick visits every entry,
// create stops at the lowest free slot. Rejected requests answer in the cycle
// after acceptance with no busy time. After reset a clearing pass zeroes the
// table under busy; no stalls.
module multi_token_bucket_table #(
  parameter int NUM_BUCKETS = mtbt_pkg::NUM_BUCKETS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [mtbt_pkg::OP_W-1:0]    in_op,
  input  logic [mtbt_pkg::BKT_W-1:0]   in_bucket,
  input  logic [mtbt_pkg::CNT_W-1:0]   in_rate,
  input  logic [mtbt_pkg::CNT_W-1:0]   in_capacity,
  input  logic [mtbt_pkg::CNT_W-1:0]   in_count,
  output logic                         out_valid,
  output logic [mtbt_pkg::STAT_W-1:0]  out_status,
  output logic [mtbt_pkg::BKT_W-1:0]   out_new_bucket,
  output logic [mtbt_pkg::CNT_W-1:0]   out_granted
);

  localparam int AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  // wide enough for both the bucket field and any table address
  localparam int CW = ((AW > mtbt_pkg::BKT_W) ? AW : mtbt_pkg::BKT_W) + 1;
  localparam logic [AW-1:0] LAST = AW'(NUM_BUCKETS - 1);

  localparam int CNT_W = mtbt_pkg::CNT_W;
  localparam int BKT_W = mtbt_pkg::BKT_W;

  function automatic logic [CNT_W-1:0] add_sat(input logic [CNT_W-1:0] base,
                                               input logic [CNT_W-1:0] more,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] sum;
    sum = {1'b0, base} + {1'b0, more};
    if (sum > {1'b0, cap}) begin
      return cap;
    end
    return sum[CNT_W-1:0];
  endfunction

  // control
  mtbt_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;       // scan / clear address
  logic             issue_r, issue_nxt;   // scan reads still to issue
  logic             dq_vld_r, dq_vld_nxt; // RAM output holds a scan entry
  logic             out_valid_r, out_valid_nxt;

  // payload
  mtbt_pkg::op_t    op_r, op_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [AW-1:0]    dq_addr_r, dq_addr_nxt;
  logic [CNT_W-1:0] rate_r, rate_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [mtbt_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [BKT_W-1:0] out_new_bucket_r, out_new_bucket_nxt;
  logic [CNT_W-1:0] out_granted_r, out_granted_nxt;

  // memory port
  logic                             wr_en, rd_en;
  logic [AW-1:0]                    wr_addr, rd_addr;
  logic [mtbt_pkg::ENTRY_W-1:0]     rd_data;
  mtbt_pkg::entry_t                 wr_entry, rd_entry;

  logic [CW-1:0]    idx_ext;
  logic             idx_bad;
  logic [CNT_W-1:0] grant;
  logic             scan_last;

  assign idx_ext   = CW'(in_bucket);
  assign idx_bad   = idx_ext >= CW'(NUM_BUCKETS);
  assign rd_entry  = mtbt_pkg::entry_t'(rd_data);
  assign grant     = (rd_entry.tokens < cnt_r) ? rd_entry.tokens : cnt_r;
  assign scan_last = dq_addr_r == LAST;

  mtbt_ram #(
    .WIDTH (mtbt_pkg::ENTRY_W),
    .DEPTH (NUM_BUCKETS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtbt_pkg::S_CLEAR;
      ptr_r       <= '0;
      issue_r     <= 1'b0;
      dq_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      issue_r     <= issue_nxt;
      dq_vld_r    <= dq_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r             <= op_nxt;
    addr_r           <= addr_nxt;
    dq_addr_r        <= dq_addr_nxt;
    rate_r           <= rate_nxt;
    cap_r            <= cap_nxt;
    cnt_r            <= cnt_nxt;
    out_status_r     <= out_status_nxt;
    out_new_bucket_r <= out_new_bucket_nxt;
    out_granted_r    <= out_granted_nxt;
  end

  always_comb begin
    state_nxt          = state_r;
    ptr_nxt            = ptr_r;
    issue_nxt          = issue_r;
    dq_vld_nxt         = 1'b0;
    dq_addr_nxt        = dq_addr_r;
    out_valid_nxt      = 1'b0;
    op_nxt             = op_r;
    addr_nxt           = addr_r;
    rate_nxt           = rate_r;
    cap_nxt            = cap_r;
    cnt_nxt            = cnt_r;
    out_status_nxt     = out_status_r;
    out_new_bucket_nxt = out_new_bucket_r;
    out_granted_nxt    = out_granted_r;
    wr_en              = 1'b0;
    wr_addr            = addr_r;
    wr_entry           = rd_entry;
    rd_en              = 1'b0;
    rd_addr            = AW'(idx_ext);

    case (state_r)
      mtbt_pkg::S_CLEAR: begin
        // zero every entry once after reset
        wr_en    = 1'b1;
        wr_addr  = ptr_r;
        wr_entry = '0;
        ptr_nxt  = ptr_r + 1'b1;
        if (ptr_r == LAST) begin
          state_nxt = mtbt_pkg::S_IDLE;
        end
      end

      mtbt_pkg::S_IDLE: begin
        if (start) begin
          op_nxt             = mtbt_pkg::op_t'(in_op);
          addr_nxt           = AW'(idx_ext);
          rate_nxt           = in_rate;
          cap_nxt            = in_capacity;
          cnt_nxt            = in_count;
          out_new_bucket_nxt = '0;
          out_granted_nxt    = '0;
          out_status_nxt     = mtbt_pkg::STAT_BAD_ARG;
          case (in_op)
            mtbt_pkg::OP_CREATE,
            mtbt_pkg::OP_TICK: begin
              if (in_op == mtbt_pkg::OP_CREATE &&
                  (in_rate == '0 || in_capacity == '0)) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = mtbt_pkg::S_SCAN;
                ptr_nxt   = '0;
                issue_nxt = 1'b1;
              end
            end
            mtbt_pkg::OP_DESTROY: begin
              if (idx_bad) begin
                out_valid_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = mtbt_pkg::S_MOD;
              end
            end
            mtbt_pkg::OP_FETCH,
            mtbt_pkg::OP_RETURN: begin
              // range and zero count are both argument errors
              if (idx_bad || in_count == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = mtbt_pkg::S_MOD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      mtbt_pkg::S_MOD: begin
        // entry read at acceptance is on the RAM output now
        state_nxt      = mtbt_pkg::S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = mtbt_pkg::STAT_OK;
        if (!rd_entry.live) begin
          out_status_nxt = mtbt_pkg::STAT_NO_BUCKET;
        end else begin
          case (op_r)
            mtbt_pkg::OP_DESTROY: begin
              wr_en         = 1'b1;
              wr_entry.live = 1'b0;
            end
            mtbt_pkg::OP_FETCH: begin
              if (rd_entry.tokens == '0) begin
                out_status_nxt = mtbt_pkg::STAT_NO_TOKENS;
              end else begin
                wr_en           = 1'b1;
                wr_entry.tokens = rd_entry.tokens - grant;
                out_granted_nxt = grant;
              end
            end
            mtbt_pkg::OP_RETURN: begin
              wr_en           = 1'b1;
              wr_entry.tokens = add_sat(rd_entry.tokens, cnt_r, rd_entry.burst_limit);
            end
            default: begin
              out_status_nxt = mtbt_pkg::STAT_BAD_ARG;
            end
          endcase
        end
      end

      mtbt_pkg::S_SCAN: begin
        // read one entry a cycle; handle the one read the cycle before
        rd_en       = issue_r;
        rd_addr     = ptr_r;
        dq_vld_nxt  = issue_r;
        dq_addr_nxt = ptr_r;
        if (issue_r) begin
          ptr_nxt = ptr_r + 1'b1;
          if (ptr_r == LAST) begin
            issue_nxt = 1'b0;
          end
        end
        wr_addr = dq_addr_r;
        if (dq_vld_r) begin
          if (op_r == mtbt_pkg::OP_CREATE) begin
            if (!rd_entry.live) begin
              // lowest free slot found
              wr_en                = 1'b1;
              wr_entry.live        = 1'b1;
              wr_entry.tokens      = '0;
              wr_entry.fill_rate   = rate_r;
              wr_entry.burst_limit = cap_r;
              out_valid_nxt        = 1'b1;
              out_status_nxt       = mtbt_pkg::STAT_OK;
              out_new_bucket_nxt   = BKT_W'(CW'(dq_addr_r));
              issue_nxt            = 1'b0;
              dq_vld_nxt           = 1'b0;
              state_nxt            = mtbt_pkg::S_IDLE;
            end else if (scan_last) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = mtbt_pkg::STAT_FULL;
              state_nxt      = mtbt_pkg::S_IDLE;
            end
          end else begin
            if (rd_entry.live) begin
              wr_en           = 1'b1;
              wr_entry.tokens = add_sat(rd_entry.tokens, rd_entry.fill_rate,
                                        rd_entry.burst_limit);
            end
            if (scan_last) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = mtbt_pkg::STAT_OK;
              state_nxt      = mtbt_pkg::S_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = mtbt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy           = state_r != mtbt_pkg::S_IDLE;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_new_bucket = out_new_bucket_r;
  assign out_granted    = out_granted_r;

endmodule

FILE: dv/tb_multi_token_bucket_table.sv
`timescale 1ns / 100ps

module tb_multi_token_bucket_table;

  localparam int OP_W       = mtbt_pkg::OP_W;
  localparam int BKT_W      = mtbt_pkg::BKT_W;
  localparam int CNT_W      = mtbt_pkg::CNT_W;
  localparam int STAT_W     = mtbt_pkg::STAT_W;
  localparam int N_SLOTS    = mtbt_pkg::NUM_BUCKETS_DEF;
  localparam int OP_TOP     = (1 << OP_W) - 1;  // highest op encoding the port can carry
  localparam int MAX_GAP    = 17;               // longest idle spell before a request
  localparam int SHOWN_MAX  = 10;               // mismatches reported in full
  // Quiet cycles tolerated: ample for the post-reset clearing pass and for a
  // full-table walk (tick or create).
  localparam int IDLE_LIMIT = 8000;

  // One answer as the block should give it.
  typedef struct packed {
    mtbt_pkg::status_t status;
    logic [BKT_W-1:0]  new_bucket;
    logic [CNT_W-1:0]  granted;
  } reply_t;

  // Shadow of the bucket table plus the queue of answers still owed.
  class bucket_table_checker;
    bit               live  [N_SLOTS];
    logic [CNT_W-1:0] level [N_SLOTS];
    logic [CNT_W-1:0] rate  [N_SLOTS];
    logic [CNT_W-1:0] limit [N_SLOTS];
    reply_t           owed_q [$];
    int               mismatches;
    int               checked;
    int               status_seen [8];

    function new();
      for (int i = 0; i < N_SLOTS; i++) begin
        live[i]  = 1'b0;
        level[i] = '0;
        rate[i]  = '0;
        limit[i] = '0;
      end
      mismatches = 0;
      checked    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // add with saturation at the burst limit
    function logic [CNT_W-1:0] fill_sat(logic [CNT_W-1:0] base, logic [CNT_W-1:0] more,
                                        logic [CNT_W-1:0] cap);
      logic [CNT_W:0] sum;
      sum = {1'b0, base} + {1'b0, more};
      return (sum > {1'b0, cap}) ? cap : sum[CNT_W-1:0];
    endfunction

    // Called on every accepted request, in acceptance order.
    function void note_request(logic [OP_W-1:0] op, logic [BKT_W-1:0] bkt,
                               logic [CNT_W-1:0] r, logic [CNT_W-1:0] c,
                               logic [CNT_W-1:0] n);
      reply_t rep;
      int     slot;
      rep  = '{status: mtbt_pkg::STAT_OK, new_bucket: '0, granted: '0};
      slot = -1;
      case (op)
        mtbt_pkg::OP_CREATE: begin
          if (r == 0 || c == 0) begin
            rep.status = mtbt_pkg::STAT_BAD_ARG;
          end else begin
            for (int i = 0; i < N_SLOTS && slot < 0; i++)
              if (!live[i]) slot = i;
            if (slot < 0) begin
              rep.status = mtbt_pkg::STAT_FULL;
            end else begin
              live[slot]     = 1'b1;
              rate[slot]     = r;
              limit[slot]    = c;
              level[slot]    = '0;
              rep.new_bucket = slot[BKT_W-1:0];
            end
          end
        end
        mtbt_pkg::OP_DESTROY: begin
          if (bkt >= N_SLOTS) rep.status = mtbt_pkg::STAT_BAD_ARG;
          else if (!live[bkt]) rep.status = mtbt_pkg::STAT_NO_BUCKET;
          else live[bkt] = 1'b0;
        end
        mtbt_pkg::OP_FETCH: begin
          if (bkt >= N_SLOTS || n == 0) begin
            rep.status = mtbt_pkg::STAT_BAD_ARG;
          end else if (!live[bkt]) begin
            rep.status = mtbt_pkg::STAT_NO_BUCKET;
          end else if (level[bkt] == 0) begin
            rep.status = mtbt_pkg::STAT_NO_TOKENS;
          end else begin
            rep.granted = (level[bkt] < n) ? level[bkt] : n;
            level[bkt]  = level[bkt] - rep.granted;
          end
        end
        mtbt_pkg::OP_RETURN: begin
          if (bkt >= N_SLOTS || n == 0) rep.status = mtbt_pkg::STAT_BAD_ARG;
          else if (!live[bkt]) rep.status = mtbt_pkg::STAT_NO_BUCKET;
          else level[bkt] = fill_sat(level[bkt], n, limit[bkt]);
        end
        mtbt_pkg::OP_TICK: begin
          for (int i = 0; i < N_SLOTS; i++)
            if (live[i]) level[i] = fill_sat(level[i], rate[i], limit[i]);
        end
        default: rep.status = mtbt_pkg::STAT_BAD_ARG;
      endcase
      status_seen[rep.status]++;
      owed_q.push_back(rep);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= SHOWN_MAX) $display("MISMATCH at %0t: %s", $time, what);
    endfunction

    // Called on every result strobe; compares against the oldest owed answer.
    function void check_result(logic [STAT_W-1:0] st, logic [BKT_W-1:0] nb,
                               logic [CNT_W-1:0] gr);
      reply_t want;
      if (owed_q.size() == 0) begin
        flag($sformatf("unexpected result status=%0d new_bucket=%0d granted=%0d",
                       st, nb, gr));
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (st !== want.status)
        flag($sformatf("status expected %s (%0d) got %0d", want.status.name(),
                       want.status, st));
      if (nb !== want.new_bucket)
        flag($sformatf("new_bucket expected %0d got %0d", want.new_bucket, nb));
      if (gr !== want.granted)
        flag($sformatf("granted expected %0d got %0d", want.granted, gr));
    endfunction

    function int live_count();
      int k;
      k = 0;
      for (int i = 0; i < N_SLOTS; i++) k += live[i];
      return k;
    endfunction

    // random live slot, or -1 when the table is empty
    function int any_live();
      int idx [$];
      for (int i = 0; i < N_SLOTS; i++)
        if (live[i]) idx.push_back(i);
      if (idx.size() == 0) return -1;
      return idx[$urandom_range(0, idx.size() - 1)];
    endfunction
  endclass

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               start       = 1'b0;
  logic [OP_W-1:0]    in_op       = '0;
  logic [BKT_W-1:0]   in_bucket   = '0;
  logic [CNT_W-1:0]   in_rate     = '0;
  logic [CNT_W-1:0]   in_capacity = '0;
  logic [CNT_W-1:0]   in_count    = '0;
  logic               busy;
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [BKT_W-1:0]   out_new_bucket;
  logic [CNT_W-1:0]   out_granted;

  bucket_table_checker board;
  int                  sent;
  int                  quiet;
  bit                  steady;  // set: requests go back to back, no idle gaps

  multi_token_bucket_table uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_bucket      (in_bucket),
    .in_rate        (in_rate),
    .in_capacity    (in_capacity),
    .in_count       (in_count),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_new_bucket (out_new_bucket),
    .out_granted    (out_granted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: the receiver can't stall, so every strobe is taken as it comes.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      board.check_result(out_status, out_new_bucket, out_granted);
  end

  // Watchdog: counts edges at which neither a request nor a result moves.
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive one request. Always entered at a rising edge; start is only lowered
  // when a gap follows, so back-to-back requests keep it high throughout.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [BKT_W-1:0] bkt,
                              input logic [CNT_W-1:0] r, input logic [CNT_W-1:0] c,
                              input logic [CNT_W-1:0] n);
    int gap;
    if ($urandom_range(0, 39) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_op       <= op;
    in_bucket   <= bkt;
    in_rate     <= r;
    in_capacity <= c;
    in_count    <= n;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_request(op, bkt, r, c, n);
    sent++;
  endtask

  // Hold the request side off until every owed answer is in.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (board.owed_q.size() != 0);
  endtask

  // Amounts: mostly modest, with the extremes and full-range values mixed in.
  function automatic logic [CNT_W-1:0] draw_amount();
    case ($urandom_range(0, 9))
      0:       return 16'd1;
      1:       return '1;
      2, 3:    return CNT_W'($urandom);
      default: return CNT_W'($urandom_range(1, 200));
    endcase
  endfunction

  // Target slot: usually a live one, otherwise any index (mostly dead ones).
  function automatic logic [BKT_W-1:0] draw_slot();
    int s;
    s = board.any_live();
    if (s >= 0 && $urandom_range(0, 99) < 85) return s[BKT_W-1:0];
    return BKT_W'($urandom);
  endfunction

  // Malformed requests: unknown op, zero arguments, dead buckets.
  task automatic send_noise();
    mtbt_pkg::op_t pick;
    case ($urandom_range(0, 3))
      0: send_request(OP_W'($urandom_range(int'(mtbt_pkg::OP_TICK) + 1, OP_TOP)),
                      BKT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom),
                      CNT_W'($urandom));
      1: begin
        if ($urandom_range(0, 1) != 0)
          send_request(mtbt_pkg::OP_CREATE, BKT_W'($urandom), '0, draw_amount(),
                       CNT_W'($urandom));
        else
          send_request(mtbt_pkg::OP_CREATE, BKT_W'($urandom), draw_amount(), '0,
                       CNT_W'($urandom));
      end
      2: begin
        pick = ($urandom_range(0, 1) != 0) ? mtbt_pkg::OP_FETCH : mtbt_pkg::OP_RETURN;
        send_request(pick, draw_slot(), CNT_W'($urandom), CNT_W'($urandom), '0);
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       pick = mtbt_pkg::OP_DESTROY;
          1:       pick = mtbt_pkg::OP_FETCH;
          default: pick = mtbt_pkg::OP_RETURN;
        endcase
        send_request(pick, BKT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom),
                     draw_amount());
      end
    endcase
  endtask

  // One random request by percentage weights; the remainder goes to noise.
  // Creates turn into destroys once live_cap buckets are in use.
  task automatic send_mixed(input int w_cre, input int w_des, input int w_fet,
                            input int w_ret, input int w_tick, input int live_cap);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_cre && board.live_count() < live_cap)
      send_request(mtbt_pkg::OP_CREATE, BKT_W'($urandom), draw_amount(), draw_amount(),
                   CNT_W'($urandom));
    else if (r < w_cre + w_des)
      send_request(mtbt_pkg::OP_DESTROY, draw_slot(), CNT_W'($urandom), CNT_W'($urandom),
                   CNT_W'($urandom));
    else if (r < w_cre + w_des + w_fet)
      send_request(mtbt_pkg::OP_FETCH, draw_slot(), CNT_W'($urandom), CNT_W'($urandom),
                   draw_amount());
    else if (r < w_cre + w_des + w_fet + w_ret)
      send_request(mtbt_pkg::OP_RETURN, draw_slot(), CNT_W'($urandom), CNT_W'($urandom),
                   draw_amount());
    else if (r < w_cre + w_des + w_fet + w_ret + w_tick)
      send_request(mtbt_pkg::OP_TICK, BKT_W'($urandom), CNT_W'($urandom),
                   CNT_W'($urandom), CNT_W'($urandom));
    else
      send_noise();
  endtask

  initial begin
    board  = new();
    sent   = 0;
    steady = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // the block runs a clearing pass here; the first request simply waits on busy

    // --- directed: argument checks, extremes, saturation, slot reuse ---
    send_request(mtbt_pkg::OP_CREATE, '0, '0, 16'd5, 16'd1);       // zero rate
    send_request(mtbt_pkg::OP_CREATE, '0, 16'd5, '0, 16'd1);       // zero capacity
    send_request(mtbt_pkg::OP_CREATE, '1, '1, '1, '1);             // slot 0, widest bucket
    send_request(mtbt_pkg::OP_CREATE, '0, 16'd1, 16'd1, '0);       // slot 1, narrowest
    send_request(mtbt_pkg::OP_CREATE, '0, 16'd3, 16'd10, '0);      // slot 2
    send_request(mtbt_pkg::OP_FETCH, 10'd0, '0, '0, 16'd5);        // live but empty
    send_request(mtbt_pkg::OP_FETCH, 10'd0, '1, '1, '0);           // zero count
    send_request(mtbt_pkg::OP_RETURN, 10'd0, '1, '1, '0);          // zero count
    send_request(mtbt_pkg::OP_FETCH, '1, '0, '0, 16'd1);           // dead slot
    send_request(mtbt_pkg::OP_RETURN, '1, '0, '0, 16'd1);          // dead slot
    send_request(mtbt_pkg::OP_DESTROY, '1, '0, '0, '0);            // dead slot
    send_request(mtbt_pkg::OP_TICK, '0, '0, '0, '0);
    send_request(mtbt_pkg::OP_FETCH, 10'd0, '0, '0, '1);           // drains the 65535
    send_request(mtbt_pkg::OP_RETURN, 10'd1, '0, '0, '1);          // full, stays at limit
    send_request(mtbt_pkg::OP_FETCH, 10'd1, '0, '0, 16'd2);        // limited by tokens
    send_request(mtbt_pkg::OP_RETURN, 10'd2, '0, '0, 16'd4);
    send_request(mtbt_pkg::OP_TICK, '1, '1, '1, '1);               // slot 2 reaches 10
    send_request(mtbt_pkg::OP_FETCH, 10'd2, '0, '0, '1);
    for (int k = int'(mtbt_pkg::OP_TICK) + 1; k <= OP_TOP; k++)
      send_request(OP_W'(k), '1, '1, '1, '1);                      // undefined ops
    send_request(mtbt_pkg::OP_DESTROY, 10'd1, '0, '0, '0);
    send_request(mtbt_pkg::OP_CREATE, '0, 16'd2, 16'd2, '0);       // reclaims slot 1
    send_request(mtbt_pkg::OP_DESTROY, 10'd1, '0, '0, '0);
    send_request(mtbt_pkg::OP_FETCH, 10'd1, '0, '0, 16'd1);        // just destroyed
    drain_results();

    // --- random traffic on a sparsely populated table ---
    repeat (500) begin
      send_mixed(15, 10, 30, 22, 5, 48);
      if ($urandom_range(0, 99) == 0) drain_results();
    end
    drain_results();

    // --- fill every slot, so creates scan deep and high indices get used ---
    while (board.live_count() < N_SLOTS) begin
      if ($urandom_range(0, 19) == 0)
        send_request(($urandom_range(0, 1) != 0) ? mtbt_pkg::OP_FETCH : mtbt_pkg::OP_RETURN,
                     draw_slot(), CNT_W'($urandom), CNT_W'($urandom), draw_amount());
      else if ($urandom_range(0, 299) == 0)
        send_request(mtbt_pkg::OP_TICK, BKT_W'($urandom), '0, '0, '0);
      else
        send_request(mtbt_pkg::OP_CREATE, BKT_W'($urandom), draw_amount(), draw_amount(),
                     CNT_W'($urandom));
    end
    drain_results();

    // --- table at or near full: full-table refusals and reuse of freed slots ---
    repeat (110) send_mixed(30, 20, 20, 15, 5, N_SLOTS + 1);
    drain_results();
    repeat (30) @(posedge clk);

    $display("Run covered %0d requests, %0d answers checked, table filled to %0d slots.",
             sent, board.checked, N_SLOTS);
    $display("Answers: ok %0d, bad argument %0d, no bucket %0d, full %0d, no tokens %0d.",
             board.status_seen[mtbt_pkg::STAT_OK], board.status_seen[mtbt_pkg::STAT_BAD_ARG],
             board.status_seen[mtbt_pkg::STAT_NO_BUCKET],
             board.status_seen[mtbt_pkg::STAT_FULL],
             board.status_seen[mtbt_pkg::STAT_NO_TOKENS]);
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", board.mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
